>>> sv/running_prefix_average_unit_macros.svh
// Assertion macros for the running prefix average unit.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef RUNNING_PREFIX_AVERAGE_UNIT_MACROS_SVH
`define RUNNING_PREFIX_AVERAGE_UNIT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define RPA_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the cycle after.
`define RPA_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/rpa_pkg.sv
// Package for the running prefix average unit: widths, queue entry, back-end states.
// No dependencies.
`default_nettype none

package rpa_pkg;

	localparam int unsigned MAX_LENGTH = 65536;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned SUM_W    = 32;
	localparam int unsigned CNT_W    = 17;
	localparam int unsigned NUM_W    = SUM_W + 2;
	localparam int unsigned MAG_W    = SUM_W + 1;
	localparam int unsigned DEN_W    = CNT_W + 1;
	localparam int unsigned QUO_W    = 16;
	localparam int unsigned ITER_W   = $clog2(QUO_W);

	localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_LENGTH);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(QUO_W - 1);

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// One classified item: sum and count after this sample, plus its flags.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        cnt;
		logic                    last;
		logic                    ovf;
	} rpa_entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ABS,
		BK_DIV,
		BK_FIX,
		BK_HOLD
	} bk_state_t;

endpackage

`default_nettype wire

>>> sv/rpa_in_if.sv
// Input sample channel: valid/ready with sample and last-sample flag.
// Depends on rpa_pkg for widths.
`default_nettype none

interface rpa_in_if import rpa_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

>>> sv/rpa_out_if.sv
// Result channel: valid/ready with rounded average, last and overflow flags.
// Depends on rpa_pkg for widths.
`default_nettype none

interface rpa_out_if import rpa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [QUO_W-1:0] average;
	logic                    last;
	logic                    overflow;

	modport source (output valid, output average, output last, output overflow, input ready);
	modport sink   (input valid, input average, input last, input overflow, output ready);
endinterface

`default_nettype wire

>>> sv/rpa_front.sv
// Front end: accepts samples, keeps the running sum and count, queues one entry per sample.
// Depends on rpa_pkg and rpa_in_if.
`default_nettype none

module rpa_front import rpa_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rpa_in_if.sink      samples,
	input  wire logic   push_ready,
	output logic        push_valid,
	output rpa_entry_t  push_entry
);

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf;
	logic signed [SUM_W-1:0] sum_new;
	logic [CNT_W-1:0]        cnt_new;
	logic                    xfer;

	assign samples.ready = push_ready;
	assign push_valid    = samples.valid;
	assign xfer          = samples.valid && push_ready;

	always_comb begin
		ovf = (cnt_q >= MAX_CNT);
		if (ovf) begin
			// hold the sequence, the sample is dropped
			sum_new = sum_q;
			cnt_new = cnt_q;
		end else begin
			sum_new = sum_q + SUM_W'(samples.sample);
			cnt_new = cnt_q + CNT_W'(1);
		end
		push_entry.sum  = sum_new;
		push_entry.cnt  = cnt_new;
		push_entry.last = samples.last_sample;
		push_entry.ovf  = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (xfer) begin
			if (samples.last_sample) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_new;
				cnt_q <= cnt_new;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/rpa_queue.sv
// Short queue of classified entries between front and back end.
// Depends on rpa_pkg.
`default_nettype none

module rpa_queue import rpa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	input  wire rpa_entry_t  push_entry,
	output logic             push_ready,
	output logic             pop_valid,
	output rpa_entry_t       pop_entry,
	input  wire logic        pop
);

	rpa_entry_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] fill_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (fill_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		if (p == Q_PTR_W'(Q_DEPTH - 1))
			return '0;
		return p + Q_PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				fill_q <= fill_q + Q_CNT_W'(1);
			else if (do_pop && !do_push)
				fill_q <= fill_q - Q_CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> sv/rpa_back.sv
// Back end: rounded mean (2*sum+count)/(2*count), truncated toward zero, by restoring division.
// Depends on rpa_pkg, rpa_out_if and the assertion macros header.
`default_nettype none
`include "running_prefix_average_unit_macros.svh"

module rpa_back import rpa_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       pop_valid,
	input  wire rpa_entry_t pop_entry,
	output logic            pop,
	rpa_out_if.source       results
);

	bk_state_t               state_q;
	bk_state_t               state_d;
	logic signed [NUM_W-1:0] num_q;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W-1:0]        rem_q;
	logic [QUO_W-1:0]        low_q;
	logic [ITER_W-1:0]       iter_q;
	logic                    neg_q;
	logic                    last_q;
	logic                    ovf_q;
	logic signed [QUO_W-1:0] avg_q;

	logic signed [NUM_W-1:0] num_d;
	logic [NUM_W-1:0]        mag;
	logic [DEN_W:0]          shifted;
	logic [DEN_W:0]          diff;
	logic                    take;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (pop_valid) state_d = BK_ABS;
			BK_ABS:  state_d = BK_DIV;
			BK_DIV:  if (iter_q == ITER_LAST) state_d = BK_FIX;
			BK_FIX:  state_d = BK_HOLD;
			BK_HOLD: if (results.ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop           = (state_q == BK_IDLE) && pop_valid;
		results.valid = (state_q == BK_HOLD);
	end

	assign results.average  = avg_q;
	assign results.last     = last_q;
	assign results.overflow = ovf_q;

	always_comb begin
		num_d   = {pop_entry.sum[SUM_W-1], pop_entry.sum, 1'b0}
			+ {{(NUM_W-CNT_W){1'b0}}, pop_entry.cnt};
		mag     = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
		shifted = {rem_q, low_q[QUO_W-1]};
		diff    = shifted - {1'b0, den_q};
		take    = !diff[DEN_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					num_q  <= num_d;
					den_q  <= {pop_entry.cnt, 1'b0};
					last_q <= pop_entry.last;
					ovf_q  <= pop_entry.ovf;
				end
			end
			BK_ABS: begin
				// quotient fits QUO_W bits, so the upper dividend bits seed the remainder
				neg_q  <= num_q[NUM_W-1];
				rem_q  <= {1'b0, mag[MAG_W-1:QUO_W]};
				low_q  <= mag[QUO_W-1:0];
				iter_q <= '0;
			end
			BK_DIV: begin
				rem_q  <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
				low_q  <= {low_q[QUO_W-2:0], take};
				iter_q <= iter_q + ITER_W'(1);
			end
			BK_FIX: begin
				avg_q <= neg_q ? QUO_W'(-low_q) : QUO_W'(low_q);
			end
			default: begin
			end
		endcase
	end

	`RPA_ASSERT_SAME(a_rem_below_den, state_q == BK_DIV, rem_q < den_q, "remainder not below divisor")
	`RPA_ASSERT_SAME(a_den_nonzero, state_q == BK_ABS || state_q == BK_DIV, den_q != '0, "zero divisor")
	`RPA_ASSERT_NEXT(a_div_ends, state_q == BK_DIV && iter_q == ITER_LAST, state_q == BK_FIX, "division did not end after last step")
	`RPA_ASSERT_NEXT(a_hold_result, state_q == BK_HOLD && !results.ready, state_q == BK_HOLD && $stable(avg_q), "result lost while stalled")

endmodule

`default_nettype wire

>>> sv/running_prefix_average_unit.sv
// Top level of the running prefix average unit: front end, queue, divider back end.
// Depends on rpa_pkg, rpa_in_if, rpa_out_if, rpa_front, rpa_queue, rpa_back.
//
//  channel   | dir | payload                          | handshake
//  ----------+-----+----------------------------------+--------------------------
//  samples   | in  | sample[15:0] s, last_sample      | valid/ready, transfer
//  results   | out | average[15:0] s, last, overflow  | valid/ready, transfer
//
// Each result passes from queue to output in steps: one to form the numerator, one
// for its magnitude, 16 restoring-division steps, one to restore the sign.
// The single shared divider takes no new entry until the last result has left.
// The front end takes a transfer in any cycle while the two-entry queue has room.
// Reset clears sum, count, queue pointers and the back-end state machine.
`default_nettype none

module running_prefix_average_unit import rpa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rpa_in_if.sink    samples,
	rpa_out_if.source results
);

	logic       push_valid;
	logic       push_ready;
	rpa_entry_t push_entry;
	logic       pop_valid;
	rpa_entry_t pop_entry;
	logic       pop;

	rpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	rpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop)
	);

	rpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop       (pop),
		.results   (results)
	);

endmodule

`default_nettype wire
